/* design/cau_pkg.sv */
// Shared constants and types for the complex arithmetic unit.
// Used by cau_div_lane, complex_arithmetic_unit and the testbench; no dependencies.
`default_nettype none
package cau_pkg;
   localparam int FRACTION_BITS_DEFAULT = 16;
   localparam int WORD_BITS = 32;
   localparam int WIDE_BITS = 64;
   localparam int QUO_BITS  = 33;

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_SUB = 2'd1;
   localparam logic [1:0] KIND_MUL = 2'd2;
   localparam logic [1:0] KIND_DIV = 2'd3;

   typedef struct packed {
      logic                 is_div;
      logic                 dz;
      logic                 neg_re;
      logic                 neg_im;
      logic                 big_re;
      logic                 big_im;
      logic [WIDE_BITS-1:0] mag_re;
      logic [WIDE_BITS-1:0] mag_im;
   } meta_type;
endpackage
`default_nettype wire

/* design/cau_div_lane.sv */
// Pipelined restoring divider lane, one quotient bit per register stage.
// Depends on cau_pkg for the word widths and the quotient length.
`default_nettype none
module cau_div_lane (
   input  wire                            clock,
   input  wire                            en,
   input  wire [cau_pkg::WIDE_BITS-1:0]   den_in,
   input  wire [cau_pkg::WIDE_BITS-1:0]   rem_in,
   input  wire [cau_pkg::QUO_BITS-1:0]    bits_in,
   output logic [cau_pkg::QUO_BITS-1:0]   quo_out
);
   import cau_pkg::*;

   logic [WIDE_BITS-1:0] rem_ff  [QUO_BITS];
   logic [WIDE_BITS-1:0] den_ff  [QUO_BITS];
   logic [QUO_BITS-1:0]  bits_ff [QUO_BITS];
   logic [QUO_BITS-1:0]  quo_ff  [QUO_BITS];

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
      logic [WIDE_BITS-1:0] src_rem;
      logic [WIDE_BITS-1:0] src_den;
      logic [QUO_BITS-1:0]  src_bits;
      logic [QUO_BITS-1:0]  src_quo;
      logic [WIDE_BITS:0]   partial;
      logic                 ge;
      logic [WIDE_BITS:0]   rem_in_w;

      if (k == 0) begin : g_first
         assign src_rem  = rem_in;
         assign src_den  = den_in;
         assign src_bits = bits_in;
         assign src_quo  = '0;
      end else begin : g_next
         assign src_rem  = rem_ff[k-1];
         assign src_den  = den_ff[k-1];
         assign src_bits = bits_ff[k-1];
         assign src_quo  = quo_ff[k-1];
      end

      always_comb begin
         partial  = {src_rem, src_bits[QUO_BITS-1]};
         ge       = partial >= {1'b0, src_den};
         rem_in_w = ge ? (partial - {1'b0, src_den}) : partial;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in_w[WIDE_BITS-1:0];
            den_ff[k]  <= src_den;
            bits_ff[k] <= {src_bits[QUO_BITS-2:0], 1'b0};
            quo_ff[k]  <= {src_quo[QUO_BITS-2:0], ge};
         end
      end
   end

   assign quo_out = quo_ff[QUO_BITS-1];
endmodule
`default_nettype wire

/* design/complex_arithmetic_unit.sv */
// Complex add, subtract, multiply and divide on signed fixed-point operands.
// Depends on cau_pkg and cau_div_lane.
//
// One item enters per cycle while the pipeline is not held, and its result passes
// through 38 register stages: input register, six 32x32 multipliers, a sum stage,
// a divide setup stage, 33 restoring divider steps (one quotient bit each) and
// the output register.
// The whole pipeline holds while a result waits and rsp_tready is low.
// Results are truncated toward zero and saturated; a zero divisor gives zero.
`default_nettype none
module complex_arithmetic_unit #(
   parameter int FRACTION_BITS = cau_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // first_real, first_imag, second_real, second_imag
   input  wire [127:0] req_tdata,
   // kind
   input  wire [1:0]   req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // result_real, result_imag
   output logic [63:0] rsp_tdata,
   // overflow, divide_by_zero
   output logic [1:0]  rsp_tuser
);
   import cau_pkg::*;

   localparam int XW = WIDE_BITS + QUO_BITS;

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // stage 1: operands
   logic              v1_ff;
   logic [1:0]        kind1_ff;
   logic signed [31:0] r1_ff, i1_ff, r2_ff, i2_ff;

   // stage 2: products
   logic              v2_ff;
   logic [1:0]        kind2_ff;
   logic signed [31:0] r1b_ff, i1b_ff, r2b_ff, i2b_ff;
   logic signed [63:0] rr_ff, ii_ff, ri_ff, ir_ff, dr_ff, di_ff;

   // stage 3: sign and magnitude
   logic              v3_ff;
   logic [1:0]        kind3_ff;
   logic              neg_re3_ff, neg_im3_ff;
   logic [63:0]       mag_re3_ff, mag_im3_ff, den3_ff;
   logic signed [65:0] s_re_in, s_im_in;
   logic [65:0]       a_re_in, a_im_in;

   // stage 4: divider setup
   logic              v4_ff;
   meta_type          meta4_ff;
   logic [63:0]       den4_ff, rem_re4_ff, rem_im4_ff;
   logic [QUO_BITS-1:0] bits_re4_ff, bits_im4_ff;
   logic [XW-1:0]     x_re_in, x_im_in, d_sh_in;

   logic              vd_ff   [QUO_BITS];
   meta_type          metad_ff [QUO_BITS];
   logic [QUO_BITS-1:0] q_re, q_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind1_ff <= req_tuser;
         r1_ff    <= req_tdata[31:0];
         i1_ff    <= req_tdata[63:32];
         r2_ff    <= req_tdata[95:64];
         i2_ff    <= req_tdata[127:96];

         kind2_ff <= kind1_ff;
         r1b_ff   <= r1_ff;
         i1b_ff   <= i1_ff;
         r2b_ff   <= r2_ff;
         i2b_ff   <= i2_ff;
         rr_ff    <= r1_ff * r2_ff;
         ii_ff    <= i1_ff * i2_ff;
         ri_ff    <= r1_ff * i2_ff;
         ir_ff    <= i1_ff * r2_ff;
         dr_ff    <= r2_ff * r2_ff;
         di_ff    <= i2_ff * i2_ff;
      end
   end

   always_comb begin
      case (kind2_ff)
         KIND_ADD: begin
            s_re_in = 66'(r1b_ff) + 66'(r2b_ff);
            s_im_in = 66'(i1b_ff) + 66'(i2b_ff);
         end
         KIND_SUB: begin
            s_re_in = 66'(r1b_ff) - 66'(r2b_ff);
            s_im_in = 66'(i1b_ff) - 66'(i2b_ff);
         end
         KIND_MUL: begin
            s_re_in = 66'(rr_ff) - 66'(ii_ff);
            s_im_in = 66'(ri_ff) + 66'(ir_ff);
         end
         default: begin
            s_re_in = 66'(rr_ff) + 66'(ii_ff);
            s_im_in = 66'(ir_ff) - 66'(ri_ff);
         end
      endcase
      a_re_in = s_re_in[65] ? 66'(-s_re_in) : 66'(s_re_in);
      a_im_in = s_im_in[65] ? 66'(-s_im_in) : 66'(s_im_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind3_ff   <= kind2_ff;
         neg_re3_ff <= s_re_in[65];
         neg_im3_ff <= s_im_in[65];
         mag_re3_ff <= a_re_in[63:0];
         mag_im3_ff <= a_im_in[63:0];
         den3_ff    <= 64'(dr_ff) + 64'(di_ff);
      end
   end

   always_comb begin
      x_re_in = {{QUO_BITS{1'b0}}, mag_re3_ff} << FRACTION_BITS;
      x_im_in = {{QUO_BITS{1'b0}}, mag_im3_ff} << FRACTION_BITS;
      d_sh_in = {den3_ff, {QUO_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta4_ff.is_div <= (kind3_ff == KIND_DIV);
         meta4_ff.dz     <= (kind3_ff == KIND_DIV) && (den3_ff == '0);
         meta4_ff.neg_re <= neg_re3_ff;
         meta4_ff.neg_im <= neg_im3_ff;
         meta4_ff.big_re <= x_re_in >= d_sh_in;
         meta4_ff.big_im <= x_im_in >= d_sh_in;
         meta4_ff.mag_re <= (kind3_ff == KIND_MUL) ? (mag_re3_ff >> FRACTION_BITS)
                                                   : mag_re3_ff;
         meta4_ff.mag_im <= (kind3_ff == KIND_MUL) ? (mag_im3_ff >> FRACTION_BITS)
                                                   : mag_im3_ff;
         den4_ff     <= den3_ff;
         rem_re4_ff  <= 64'(x_re_in >> QUO_BITS);
         rem_im4_ff  <= 64'(x_im_in >> QUO_BITS);
         bits_re4_ff <= x_re_in[QUO_BITS-1:0];
         bits_im4_ff <= x_im_in[QUO_BITS-1:0];
      end
   end

   cau_div_lane u_lane_re (
      .clock   (clock),
      .en      (en),
      .den_in  (den4_ff),
      .rem_in  (rem_re4_ff),
      .bits_in (bits_re4_ff),
      .quo_out (q_re)
   );

   cau_div_lane u_lane_im (
      .clock   (clock),
      .en      (en),
      .den_in  (den4_ff),
      .rem_in  (rem_im4_ff),
      .bits_in (bits_im4_ff),
      .quo_out (q_im)
   );

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_meta
      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[k] <= 1'b0;
         end else if (en) begin
            vd_ff[k] <= (k == 0) ? v4_ff : vd_ff[(k == 0) ? 0 : k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            metad_ff[k] <= (k == 0) ? meta4_ff : metad_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // final saturation
   meta_type    mf;
   logic [63:0] fm_re_in, fm_im_in;
   logic        sat_re_in, sat_im_in;
   logic [31:0] o_re_in, o_im_in;

   always_comb begin
      mf = metad_ff[QUO_BITS-1];
      if (mf.is_div) begin
         fm_re_in = mf.big_re ? 64'h0000_0001_0000_0000 : 64'(q_re);
         fm_im_in = mf.big_im ? 64'h0000_0001_0000_0000 : 64'(q_im);
      end else begin
         fm_re_in = mf.mag_re;
         fm_im_in = mf.mag_im;
      end
      sat_re_in = mf.neg_re ? (fm_re_in > 64'h8000_0000) : (fm_re_in > 64'h7FFF_FFFF);
      sat_im_in = mf.neg_im ? (fm_im_in > 64'h8000_0000) : (fm_im_in > 64'h7FFF_FFFF);
      if (sat_re_in) begin
         o_re_in = mf.neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         o_re_in = mf.neg_re ? 32'(-fm_re_in) : fm_re_in[31:0];
      end
      if (sat_im_in) begin
         o_im_in = mf.neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         o_im_in = mf.neg_im ? 32'(-fm_im_in) : fm_im_in[31:0];
      end
      if (mf.dz) begin
         o_re_in   = '0;
         o_im_in   = '0;
         sat_re_in = 1'b0;
         sat_im_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (en) begin
         rsp_tvalid <= vd_ff[QUO_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata <= {o_im_in, o_re_in};
         rsp_tuser <= {mf.dz, sat_re_in | sat_im_in};
      end
   end
endmodule
`default_nettype wire

/* test/complex_arithmetic_unit_tb.sv */
// Self-checking testbench for complex_arithmetic_unit: directed and random items
// checked against a built-in predictor of the complex results. Depends on cau_pkg.
`timescale 1ns / 1ps
module complex_arithmetic_unit_tb;
   import cau_pkg::*;

   typedef struct {
      logic [1:0]         kind;
      logic signed [31:0] fr, fi, sr, si;
   } operands_type;

   typedef struct {
      logic [31:0] re, im;
      logic        ovf, dz;
   } complex_result_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [63:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   operands_type       pending_ops[$];
   complex_result_type expected_results[$];
   int                 errors = 0;
   int                 idle_pct = 0, stall_pct = 0;
   bit                 hold = 0;

   complex_arithmetic_unit DUT (.*);

   initial forever #5 clock = ~clock;

   function automatic logic [31:0] clamp(logic signed [127:0] v, inout logic ovf);
      if (v > 128'sh7FFFFFFF) begin
         ovf = 1;
         return 32'h7FFFFFFF;
      end
      if (v < -128'sh80000000) begin
         ovf = 1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [127:0] trunc_shift(logic signed [127:0] v);
      logic [127:0] m;
      m = (v < 0) ? -v : v;
      m = m >> FRACTION_BITS_DEFAULT;
      return (v < 0) ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [127:0] trunc_div(logic signed [127:0] n,
                                                     logic [127:0] d);
      logic [127:0] m;
      m = (n < 0) ? -n : n;
      m = (m << FRACTION_BITS_DEFAULT) / d;
      return (n < 0) ? -$signed(m) : $signed(m);
   endfunction

   function automatic complex_result_type complex_op(operands_type op);
      complex_result_type r;
      logic signed [127:0] a, b, c, e, re, im;
      logic [127:0] den;
      a = op.fr;
      b = op.fi;
      c = op.sr;
      e = op.si;
      r.ovf = 0;
      r.dz = 0;
      re = 0;
      im = 0;
      case (op.kind)
         KIND_ADD: begin
            re = a + c;
            im = b + e;
         end
         KIND_SUB: begin
            re = a - c;
            im = b - e;
         end
         KIND_MUL: begin
            re = trunc_shift(a * c - b * e);
            im = trunc_shift(a * e + c * b);
         end
         default: begin
            den = c * c + e * e;
            if (den == 0) r.dz = 1;
            else begin
               re = trunc_div(a * c + b * e, den);
               im = trunc_div(b * c - a * e, den);
            end
         end
      endcase
      r.re = clamp(re, r.ovf);
      r.im = clamp(im, r.ovf);
      return r;
   endfunction

   function automatic logic [31:0] pick_word(int mode);
      case ($urandom_range(0, 9))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h0;
         3, 4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
         default: return mode ? $urandom : {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      endcase
   endfunction

   function automatic operands_type random_op();
      operands_type op;
      int mode;
      mode = $urandom_range(0, 1);
      op.kind = 2'($urandom_range(0, 3));
      op.fr = pick_word(mode);
      op.fi = pick_word(mode);
      op.sr = pick_word(mode);
      op.si = pick_word(mode);
      if (op.kind == KIND_DIV && $urandom_range(0, 9) == 0) begin
         op.sr = 0;
         op.si = 0;
      end
      return op;
   endfunction

   task automatic add_op(logic [1:0] k, logic [31:0] fr, logic [31:0] fi,
                         logic [31:0] sr, logic [31:0] si);
      operands_type op;
      op.kind = k;
      op.fr = fr;
      op.fi = fi;
      op.sr = sr;
      op.si = si;
      pending_ops.push_back(op);
   endtask

   task automatic drain();
      wait (pending_ops.size() == 0 && !req_tvalid && expected_results.size() == 0);
   endtask

   // drive: advance to the next item once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_ops.size() > 0 && !hold && $urandom_range(0, 99) >= idle_pct) begin
            operands_type op;
            op = pending_ops.pop_front();
            req_tvalid <= 1;
            req_tuser <= op.kind;
            req_tdata <= {op.si, op.sr, op.fi, op.fr};
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         operands_type op;
         op.kind = req_tuser;
         op.fr = req_tdata[31:0];
         op.fi = req_tdata[63:32];
         op.sr = req_tdata[95:64];
         op.si = req_tdata[127:96];
         expected_results.push_back(complex_op(op));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         complex_result_type x;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected item re=%h im=%h flags=%b", $time,
                     rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser);
            errors++;
         end else begin
            x = expected_results.pop_front();
            if (rsp_tdata[31:0] !== x.re) begin
               $display("%0t: real expected %h actual %h", $time, x.re, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== x.im) begin
               $display("%0t: imag expected %h actual %h", $time, x.im, rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tuser[0] !== x.ovf) begin
               $display("%0t: overflow expected %b actual %b", $time, x.ovf, rsp_tuser[0]);
               errors++;
            end
            if (rsp_tuser[1] !== x.dz) begin
               $display("%0t: divide_by_zero expected %b actual %b", $time, x.dz,
                        rsp_tuser[1]);
               errors++;
            end
         end
      end
   end

   initial begin
      #3_000_000;
      $display("complex_arithmetic_unit regression: fail");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      add_op(KIND_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      add_op(KIND_ADD, 32'h00010000, 32'hFFFF0000, 32'h00020000, 32'h00000001);
      add_op(KIND_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
      add_op(KIND_SUB, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
      add_op(KIND_SUB, 32'h80000000, 32'h00000000, 32'h00000001, 32'h80000000);
      add_op(KIND_SUB, 32'h00030000, 32'h00010000, 32'h00010000, 32'h00030000);
      add_op(KIND_MUL, 32'h00020000, 32'h00030000, 32'h00040000, 32'hFFFB0000);
      add_op(KIND_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      add_op(KIND_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
      add_op(KIND_MUL, 32'hFFFFFFFF, 32'h00000000, 32'h00000001, 32'h00000000);
      add_op(KIND_MUL, 32'h00000000, 32'h00000000, 32'h7FFFFFFF, 32'h80000000);
      add_op(KIND_DIV, 32'h00010000, 32'h00020000, 32'h00000000, 32'h00000000);
      add_op(KIND_DIV, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'h00000000);
      add_op(KIND_DIV, 32'h00050000, 32'hFFFD0000, 32'h00010000, 32'h00000000);
      add_op(KIND_DIV, 32'h00010000, 32'h00000000, 32'h00030000, 32'h00000000);
      add_op(KIND_DIV, 32'hFFFF0000, 32'h00000000, 32'h00030000, 32'h00000000);
      add_op(KIND_DIV, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000001, 32'h00000000);
      add_op(KIND_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      add_op(KIND_DIV, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      add_op(KIND_DIV, 32'h00000001, 32'hFFFFFFFF, 32'h00000000, 32'h00000001);
      add_op(KIND_DIV, 32'h00030000, 32'h00040000, 32'h00010000, 32'h00020000);
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1 || phase == 3) ? 51 : 0;
         stall_pct = (phase == 2 || phase == 3) ? 51 : 0;
         if (phase == 3) begin
            idle_pct = 8;
            stall_pct = 8;
         end
         repeat (100) pending_ops.push_back(random_op());
         wait (pending_ops.size() < 50);
         hold = 1;
         wait (!req_tvalid && expected_results.size() == 0);
         hold = 0;
         drain();
      end
      idle_pct = 0;
      stall_pct = 0;
      repeat (60) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0)
         $display("complex_arithmetic_unit regression: pass");
      else
         $display("complex_arithmetic_unit regression: fail");
      $finish;
   end
endmodule

/* filelist.f */
design/cau_pkg.sv
design/cau_div_lane.sv
design/complex_arithmetic_unit.sv
test/complex_arithmetic_unit_tb.sv
